FILE: hdl/elementary_symmetric_sum_macros.svh
// Assertion macros for the elementary symmetric sum RTL.
// The using module must have clk and arst_n in scope.
`ifndef ELEMENTARY_SYMMETRIC_SUM_MACROS_SVH
`define ELEMENTARY_SYMMETRIC_SUM_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ESS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ess: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ESS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ess: next-cycle check failed");

`endif

FILE: hdl/ess_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ess_pkg;

	// Default build values
	localparam int MAX_ORDER     = 8;
	localparam int FRACTION_BITS = 16;

	// Field widths
	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 64;
	localparam int ORDER_W  = 4;
	localparam int KEFF_W   = ORDER_W + 1;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	// Saturation limits
	localparam logic [SUM_W-1:0] SIGN64   = 64'h8000_0000_0000_0000;
	localparam logic [SUM_W-1:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;

	// One classified element: sign and magnitude split, end-of-vector mark
	typedef struct packed {
		logic                xneg;
		logic [SAMPLE_W-1:0] xmag;
		logic                last;
	} item_t;

endpackage

`default_nettype wire

FILE: hdl/ess_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ess_front (
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ess_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                         last,
	input  wire logic                         q_full,
	output logic                              push,
	output ess_pkg::item_t                    push_item
);

	// Stall only on a full queue
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Split the element into sign and magnitude
	always_comb begin
		push_item.xneg = sample_value[ess_pkg::SAMPLE_W-1];
		push_item.xmag = sample_value[ess_pkg::SAMPLE_W-1] ? (~sample_value + 32'd1)
		                                                    : sample_value;
		push_item.last = last;
	end

endmodule

`default_nettype wire

FILE: hdl/ess_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ess_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ess_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output ess_pkg::item_t      head_item
);

	ess_pkg::item_t                 entry_q [ess_pkg::QDEPTH];
	logic [ess_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ess_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ess_pkg::QPTR_W:0]       count_q;

	assign full       = (count_q == (ess_pkg::QPTR_W + 1)'(ess_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

FILE: hdl/ess_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module ess_lane #(
	parameter int FRACTION_BITS = ess_pkg::FRACTION_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic [ess_pkg::SAMPLE_W-1:0] xmag,
	input  wire logic                         xneg,
	input  wire logic [ess_pkg::SUM_W-1:0]    e_prev,
	input  wire logic [ess_pkg::SUM_W-1:0]    e_cur,
	output logic      [ess_pkg::SUM_W-1:0]    e_next,
	output logic                              sat
);

	logic        eneg;
	logic [63:0] emag;
	logic [63:0] plo_c;
	logic [63:0] pmid_c;
	logic [63:0] plo_s1;
	logic [63:0] pmid_s1;
	logic        neg_s1;
	logic [95:0] full;
	logic [95:0] shifted;
	logic [63:0] lim;
	logic        msat;
	logic [63:0] mag;
	logic [63:0] prod;
	logic [63:0] sum;
	logic        aovf;

	// Split |e| into halves, two 32x32 partial products
	assign eneg   = e_prev[63];
	assign emag   = eneg ? (~e_prev + 64'd1) : e_prev;
	assign plo_c  = emag[31:0] * xmag;
	assign pmid_c = emag[63:32] * xmag;

	// Hold partial products for the combine step
	always_ff @(posedge clk) begin
		if (load) begin
			plo_s1  <= plo_c;
			pmid_s1 <= pmid_c;
			neg_s1  <= xneg ^ eneg;
		end
	end

	// Combine, drop fraction bits toward zero, clamp magnitude
	assign full    = {32'd0, plo_s1} + {pmid_s1, 32'd0};
	assign shifted = full >> FRACTION_BITS;
	assign lim     = neg_s1 ? ess_pkg::SIGN64 : ess_pkg::MAXPOS64;
	assign msat    = (|shifted[95:64]) || (shifted[63:0] > lim);
	assign mag     = msat ? lim : shifted[63:0];
	assign prod    = neg_s1 ? (~mag + 64'd1) : mag;

	// Saturating accumulate
	assign sum    = e_cur + prod;
	assign aovf   = (e_cur[63] == prod[63]) && (sum[63] != e_cur[63]);
	assign e_next = aovf ? (e_cur[63] ? ess_pkg::SIGN64 : ess_pkg::MAXPOS64) : sum;
	assign sat    = msat || aovf;

endmodule

`default_nettype wire

FILE: hdl/ess_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "elementary_symmetric_sum_macros.svh"

module ess_back #(
	parameter int MAX_ORDER     = ess_pkg::MAX_ORDER,
	parameter int FRACTION_BITS = ess_pkg::FRACTION_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ess_pkg::ORDER_W-1:0] cfg_data,
	input  wire logic                        q_valid,
	input  wire ess_pkg::item_t              q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ess_pkg::SUM_W-1:0]        product_sum,
	output logic                             overflow
);

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [ess_pkg::SUM_W-1:0] ONE_FIX = 64'd1 << FRACTION_BITS;

	logic [ess_pkg::ORDER_W-1:0] order_q;
	logic [ess_pkg::SUM_W-1:0]   partial_q [MAX_ORDER];
	logic                        flag_q;
	logic                        valid_s1;
	logic                        last_s1;
	logic                        out_valid_q;
	logic [ess_pkg::SUM_W-1:0]   product_sum_q;
	logic                        overflow_q;

	logic [ess_pkg::SUM_W-1:0]   e_prev [MAX_ORDER];
	logic [ess_pkg::SUM_W-1:0]   e_next [MAX_ORDER];
	logic [MAX_ORDER-1:0]        lane_sat;
	logic [ess_pkg::KEFF_W-1:0]  keff;
	logic [ess_pkg::KEFF_W-1:0]  keff_m1;
	logic [IDX_W-1:0]            ksel;
	logic                        sat_any;
	logic                        out_free;
	logic                        commit;

	// Clamp the order register into 1..MAX_ORDER
	always_comb begin
		if (order_q == '0)
			keff = ess_pkg::KEFF_W'(1);
		else if ({1'b0, order_q} > ess_pkg::KEFF_W'(MAX_ORDER))
			keff = ess_pkg::KEFF_W'(MAX_ORDER);
		else
			keff = {1'b0, order_q};
	end
	assign keff_m1 = keff - ess_pkg::KEFF_W'(1);
	assign ksel    = keff_m1[IDX_W-1:0];

	// One element at a time through the two-step accumulator loop
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && (!last_s1 || out_free);
	assign q_pop    = q_valid && !valid_s1;

	// Accumulator lanes, lane j fed by the sum one order below
	for (genvar j = 0; j < MAX_ORDER; j++) begin : g_lane
		if (j == 0) begin : g_first
			assign e_prev[j] = ONE_FIX;
		end else begin : g_rest
			assign e_prev[j] = partial_q[j-1];
		end
		ess_lane #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_lane (
			.clk   (clk),
			.load  (q_pop),
			.xmag  (q_item.xmag),
			.xneg  (q_item.xneg),
			.e_prev(e_prev[j]),
			.e_cur (partial_q[j]),
			.e_next(e_next[j]),
			.sat   (lane_sat[j])
		);
	end

	// Flag saturation only in lanes up to the effective order
	always_comb begin
		sat_any = 1'b0;
		for (int j = 0; j < MAX_ORDER; j++) begin
			if (lane_sat[j] && (ess_pkg::KEFF_W'(j) < keff))
				sat_any = 1'b1;
		end
	end

	// Order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ess_pkg::ORDER_W'(1);
		end else if (cfg_we) begin
			order_q <= cfg_data;
		end
	end

	// Track the element in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
				last_s1  <= q_item.last;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Update sums and flag; clear them at the end of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_ORDER; j++)
				partial_q[j] <= '0;
			flag_q <= 1'b0;
		end else if (commit) begin
			for (int j = 0; j < MAX_ORDER; j++)
				partial_q[j] <= last_s1 ? '0 : e_next[j];
			flag_q <= last_s1 ? 1'b0 : (flag_q || sat_any);
		end
	end

	// Output register: load on a finished vector, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && last_s1) begin
			product_sum_q <= e_next[ksel];
			overflow_q    <= flag_q || sat_any;
		end
	end

	assign out_valid   = out_valid_q;
	assign product_sum = product_sum_q;
	assign overflow    = overflow_q;

	// Checks
	`ESS_ASSERT_NEXT(a_result_loaded, commit && last_s1, out_valid_q)
	`ESS_ASSERT_NEXT(a_sums_cleared, commit && last_s1,
		!flag_q && (partial_q[MAX_ORDER-1] == '0))
	`ESS_ASSERT_NEXT(a_item_held, valid_s1 && !commit, valid_s1)
	`ESS_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(commit && last_s1))

endmodule

`default_nettype wire

FILE: hdl/elementary_symmetric_sum.sv
`timescale 1ns / 1ps
`default_nettype none

// Order-k elementary symmetric polynomial over a stream of Q15.16 elements.
// Each accepted element updates the running sums e_1..e_MAX_ORDER at once
// (e_j += x * e_(j-1), with e_0 = 1.0); the element marked last produces one
// result, e_k saturated to signed Q47.16, with a flag that is set if any sum
// up to order k saturated during the vector; the sums then clear. Write the
// order register only while the block is idle; 0 acts as 1 and values above
// MAX_ORDER act as MAX_ORDER. The input side takes an element in any cycle
// while its two-entry queue has room. The accumulator takes one element at a
// time and starts the next only when the previous one is done: the 32x32
// partial products of the element and the previous sums are registered, then
// combined, rounded toward zero, clamped and added to the sums, and the
// following element needs those sums. An element marked last is added only
// while the output register is free. A result sits in the output register
// from the cycle after its last element is accumulated.
module elementary_symmetric_sum #(
	parameter int MAX_ORDER     = ess_pkg::MAX_ORDER,
	parameter int FRACTION_BITS = ess_pkg::FRACTION_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ess_pkg::ORDER_W-1:0]  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ess_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [ess_pkg::SUM_W-1:0]    product_sum,
	output logic                              overflow
);

	logic           q_full;
	logic           push;
	ess_pkg::item_t push_item;
	logic           pop;
	logic           head_valid;
	ess_pkg::item_t head_item;

	// Accept and classify elements
	ess_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_value(sample_value),
		.last        (last),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// Decouple input from the accumulator
	ess_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// Accumulate and emit results
	ess_back #(
		.MAX_ORDER    (MAX_ORDER),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.q_valid    (head_valid),
		.q_item     (head_item),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.product_sum(product_sum),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire
